>>> design/scmi_pkg.sv
// Shared constants, types and controller interface structs for the span column merge-insert core.
`timescale 1ns / 1ps
package scmi_pkg;

    localparam int MAX_COLUMNS      = 4096;
    localparam int SLOTS_PER_COLUMN = 8;
    localparam int HEIGHT_BITS      = 13;

    localparam int COL_BITS  = $clog2(MAX_COLUMNS);
    localparam int SLOT_BITS = (SLOTS_PER_COLUMN > 1) ? $clog2(SLOTS_PER_COLUMN) : 1;
    localparam int CNT_BITS  = $clog2(SLOTS_PER_COLUMN + 1);

    localparam int X_BITS    = 6;
    localparam int Z_BITS    = 6;
    localparam int AREA_BITS = 8;
    localparam int GW_BITS   = 7;
    localparam int THR_BITS  = 13;
    localparam int CFG_BITS  = 13;
    localparam int CIDX_BITS = X_BITS + Z_BITS + GW_BITS;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic CFG_GRID_WIDTH      = 1'b0;
    localparam logic CFG_MERGE_THRESHOLD = 1'b1;

    localparam logic [GW_BITS-1:0]  GRID_WIDTH_RESET = 7'd64;
    localparam logic [THR_BITS-1:0] THRESHOLD_RESET  = 13'd1;

    typedef struct packed {
        logic [HEIGHT_BITS-1:0] bot;
        logic [HEIGHT_BITS-1:0] top;
        logic [AREA_BITS-1:0]   area;
    } slot_t;

    typedef slot_t [SLOTS_PER_COLUMN-1:0] row_t;

    typedef struct packed {
        logic clear_we;
        logic load_in;
        logic check;
        logic capture;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic range_bad;
        logic cnt_zero;
        logic walk_last;
        logic out_busy;
    } dp_status_t;

endpackage

>>> design/scmi_if.sv
// Valid/ready channel interfaces for span inputs and merge results.
`timescale 1ns / 1ps
interface scmi_span_if;
    import scmi_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [X_BITS-1:0]      column_x;
    logic [Z_BITS-1:0]      column_z;
    logic [HEIGHT_BITS-1:0] span_bottom;
    logic [HEIGHT_BITS-1:0] span_top;
    logic [AREA_BITS-1:0]   area_id;
    modport source (output valid, column_x, column_z, span_bottom, span_top, area_id,
                    input ready);
    modport sink (input valid, column_x, column_z, span_bottom, span_top, area_id,
                  output ready);
endinterface

interface scmi_result_if;
    import scmi_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [HEIGHT_BITS-1:0] merged_bottom;
    logic [HEIGHT_BITS-1:0] merged_top;
    logic [AREA_BITS-1:0]   merged_area;
    logic [CNT_BITS-1:0]    column_count;
    modport source (output valid, status, merged_bottom, merged_top, merged_area,
                    column_count, input ready);
    modport sink (input valid, status, merged_bottom, merged_top, merged_area,
                  column_count, output ready);
endinterface

>>> design/scmi_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module scmi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> design/scmi_ctrl.sv
// Controller state machine sequencing clear, read, walk and write-back of one column.
`timescale 1ns / 1ps
module scmi_ctrl import scmi_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_LOAD   = 3'd4;
    localparam logic [2:0] S_WALK   = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.range_bad ? S_FINISH : S_READ;
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.capture = 1'b1;
                state_next  = stat.cnt_zero ? S_FINISH : S_WALK;
            end
            S_WALK:
            begin
                cmd.step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/scmi_dp.sv
// Datapath: column addressing, slot walk with merge, compaction, memories and result register.
`timescale 1ns / 1ps
module scmi_dp import scmi_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    scmi_span_if.sink           span,
    scmi_result_if.source       result,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          stat
);

    logic [GW_BITS-1:0]     grid_width_reg;
    logic [THR_BITS-1:0]    threshold_reg;
    logic [X_BITS-1:0]      x_reg;
    logic [Z_BITS-1:0]      z_reg;
    logic [HEIGHT_BITS-1:0] in_bot_reg;
    logic [HEIGHT_BITS-1:0] in_top_reg;
    logic [AREA_BITS-1:0]   in_area_reg;
    logic [COL_BITS-1:0]    col_reg;
    logic                   bad_reg;
    logic [COL_BITS-1:0]    clr_addr_reg;
    row_t                   row_reg;
    row_t                   kept_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [SLOT_BITS-1:0]   idx_reg;
    logic [CNT_BITS-1:0]    nk_reg;
    logic [CNT_BITS-1:0]    pos_reg;
    logic                   above_reg;
    slot_t                  ns_reg;

    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    slot_t                  out_span_reg;
    logic [CNT_BITS-1:0]    out_count_reg;

    logic [CIDX_BITS-1:0]   col_full;
    row_t                   row_rdata;
    row_t                   row_wdata;
    logic [CNT_BITS-1:0]    cnt_rdata;
    logic [CNT_BITS-1:0]    cnt_wdata;
    logic [COL_BITS-1:0]    cnt_addr;
    logic                   full;
    logic                   commit;
    slot_t                  cur;
    slot_t                  merged;
    logic [HEIGHT_BITS-1:0] diff;

    assign col_full = CIDX_BITS'(x_reg) + CIDX_BITS'(z_reg) * CIDX_BITS'(grid_width_reg);

    assign stat.range_bad  = ({1'b0, x_reg} >= grid_width_reg) ||
                             (32'(col_full) >= 32'(MAX_COLUMNS));
    assign stat.clear_last = (clr_addr_reg == COL_BITS'(MAX_COLUMNS - 1));
    assign stat.cnt_zero   = (cnt_rdata == '0);
    assign stat.walk_last  = (CNT_BITS'(idx_reg) + CNT_BITS'(1) == cnt_reg);
    assign stat.out_busy   = out_valid_reg && !result.ready;

    assign full   = (nk_reg == CNT_BITS'(SLOTS_PER_COLUMN));
    assign commit = cmd.finish && !bad_reg && !full;

    assign cur = row_reg[idx_reg];

    always_comb
    begin
        merged.bot  = (cur.bot < ns_reg.bot) ? cur.bot : ns_reg.bot;
        merged.top  = (cur.top > ns_reg.top) ? cur.top : ns_reg.top;
        diff        = merged.top - cur.top;
        merged.area = ((diff <= threshold_reg) && (cur.area > ns_reg.area)) ?
                      cur.area : ns_reg.area;
    end

    always_comb
    begin
        for (int j = 0; j < SLOTS_PER_COLUMN; j++)
        begin
            if (CNT_BITS'(j) < pos_reg)
            begin
                row_wdata[j] = kept_reg[j];
            end
            else if (CNT_BITS'(j) == pos_reg)
            begin
                row_wdata[j] = ns_reg;
            end
            else
            begin
                row_wdata[j] = kept_reg[(j > 0) ? j - 1 : 0];
            end
        end
    end

    assign cnt_addr  = cmd.clear_we ? clr_addr_reg : col_reg;
    assign cnt_wdata = cmd.clear_we ? '0 : nk_reg + CNT_BITS'(1);

    scmi_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (MAX_COLUMNS)
    ) u_row_ram (
        .clk   (clk),
        .we    (commit),
        .addr  (col_reg),
        .wdata (row_wdata),
        .rdata (row_rdata)
    );

    scmi_ram #(
        .WIDTH (CNT_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cmd.clear_we || commit),
        .addr  (cnt_addr),
        .wdata (cnt_wdata),
        .rdata (cnt_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= GRID_WIDTH_RESET;
            threshold_reg  <= THRESHOLD_RESET;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH:      grid_width_reg <= cfg_data[GW_BITS-1:0];
                    CFG_MERGE_THRESHOLD: threshold_reg  <= cfg_data[THR_BITS-1:0];
                    default:             grid_width_reg <= grid_width_reg;
                endcase
            end
            if (cmd.clear_we)
            begin
                clr_addr_reg <= clr_addr_reg + COL_BITS'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg       <= span.column_x;
            z_reg       <= span.column_z;
            in_bot_reg  <= span.span_bottom;
            in_top_reg  <= span.span_top;
            in_area_reg <= span.area_id;
        end
        if (cmd.check)
        begin
            col_reg <= col_full[COL_BITS-1:0];
            bad_reg <= stat.range_bad;
            nk_reg  <= '0;
            pos_reg <= '0;
            ns_reg  <= '{bot: in_bot_reg, top: in_top_reg, area: in_area_reg};
        end
        if (cmd.capture)
        begin
            row_reg   <= row_rdata;
            cnt_reg   <= cnt_rdata;
            idx_reg   <= '0;
            above_reg <= 1'b0;
        end
        if (cmd.step)
        begin
            idx_reg <= idx_reg + SLOT_BITS'(1);
            if (above_reg || (cur.bot > ns_reg.top))
            begin
                above_reg                       <= 1'b1;
                kept_reg[nk_reg[SLOT_BITS-1:0]] <= cur;
                nk_reg                          <= nk_reg + CNT_BITS'(1);
            end
            else if (cur.top < ns_reg.bot)
            begin
                kept_reg[nk_reg[SLOT_BITS-1:0]] <= cur;
                nk_reg                          <= nk_reg + CNT_BITS'(1);
                pos_reg                         <= nk_reg + CNT_BITS'(1);
            end
            else
            begin
                ns_reg <= merged;
            end
        end
        if (cmd.finish)
        begin
            priority if (bad_reg)
            begin
                out_status_reg <= ST_RANGE;
                out_span_reg   <= '0;
                out_count_reg  <= '0;
            end
            else if (full)
            begin
                out_status_reg <= ST_FULL;
                out_span_reg   <= '0;
                out_count_reg  <= cnt_reg;
            end
            else
            begin
                out_status_reg <= ST_INSERTED;
                out_span_reg   <= ns_reg;
                out_count_reg  <= nk_reg + CNT_BITS'(1);
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.merged_bottom = out_span_reg.bot;
    assign result.merged_top    = out_span_reg.top;
    assign result.merged_area   = out_span_reg.area;
    assign result.column_count  = out_count_reg;

endmodule

>>> design/span_column_merge_insert_core.sv
// Top level of the span column merge-insert core.
`timescale 1ns / 1ps
// Each accepted span is merged into its grid column when in range and the column has room; one
// result transfer follows every span. After reset the block sweeps and clears the column count
// memory before it takes its first span. The walk unit then examines each of the spans already
// in the column (0 to 8), one slot of the column row per cycle. Out-of-range spans skip the read
// and the walk. The next span can be accepted in the cycle after the result is loaded into the
// output register, even while that result waits.
module span_column_merge_insert_core import scmi_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    scmi_span_if.sink           span,
    scmi_result_if.source       result
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;
    logic       in_ready;

    scmi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (span.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scmi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .span      (span),
        .result    (result),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign span.ready = in_ready;

endmodule

>>> test/tb_span_column_merge_insert_core.sv
// Self-checking testbench for the span column merge-insert core with a predicted column store.
`timescale 1ns / 1ps
module tb_span_column_merge_insert_core;
    import scmi_pkg::*;

    typedef struct packed {
        logic [X_BITS-1:0]      x;
        logic [Z_BITS-1:0]      z;
        logic [HEIGHT_BITS-1:0] bot;
        logic [HEIGHT_BITS-1:0] top;
        logic [AREA_BITS-1:0]   area;
    } span_item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [HEIGHT_BITS-1:0] bot;
        logic [HEIGHT_BITS-1:0] top;
        logic [AREA_BITS-1:0]   area;
        logic [CNT_BITS-1:0]    count;
    } merge_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    scmi_span_if   span ();
    scmi_result_if result ();

    span_column_merge_insert_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .span      (span),
        .result    (result)
    );

    slot_t         column_store [MAX_COLUMNS][SLOTS_PER_COLUMN];
    int unsigned   column_fill [MAX_COLUMNS];
    int unsigned   cur_grid_width;
    int unsigned   cur_threshold;
    span_item_t    pending_spans [$];
    merge_result_t expected_results [$];
    int            mismatch_count;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_cycles;
    bit            hold_request;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic merge_result_t merge_span(span_item_t it);
        merge_result_t r;
        slot_t         ns;
        slot_t         kept [SLOTS_PER_COLUMN];
        slot_t         c;
        int unsigned   col;
        int unsigned   nk;
        int unsigned   pos;
        int unsigned   cnt;
        int unsigned   diff;
        bit            above;
        r = '0;
        ns.bot = it.bot;
        ns.top = it.top;
        ns.area = it.area;
        nk = 0;
        pos = 0;
        above = 1'b0;
        if (it.x >= cur_grid_width) begin
            r.status = ST_RANGE;
            return r;
        end
        col = it.x + it.z * cur_grid_width;
        if (col >= MAX_COLUMNS) begin
            r.status = ST_RANGE;
            return r;
        end
        cnt = column_fill[col];
        for (int i = 0; i < cnt; i++) begin
            c = column_store[col][i];
            if (above || c.bot > ns.top) begin
                above = 1'b1;
                kept[nk] = c;
                nk++;
            end else if (c.top < ns.bot) begin
                kept[nk] = c;
                nk++;
                pos = nk;
            end else begin
                if (c.bot < ns.bot) ns.bot = c.bot;
                if (c.top > ns.top) ns.top = c.top;
                diff = (ns.top >= c.top) ? ns.top - c.top : c.top - ns.top;
                if (diff <= cur_threshold && c.area > ns.area) ns.area = c.area;
            end
        end
        if (nk + 1 > SLOTS_PER_COLUMN) begin
            r.status = ST_FULL;
            r.count = CNT_BITS'(cnt);
            return r;
        end
        for (int i = 0; i < pos; i++) column_store[col][i] = kept[i];
        column_store[col][pos] = ns;
        for (int i = pos; i < nk; i++) column_store[col][i + 1] = kept[i];
        column_fill[col] = nk + 1;
        r.status = ST_INSERTED;
        r.bot = ns.bot;
        r.top = ns.top;
        r.area = ns.area;
        r.count = CNT_BITS'(nk + 1);
        return r;
    endfunction

    // Driver: the expectation is formed when the transfer happens, in source order.
    always @(posedge clk)
    begin
        if (span.valid && span.ready) begin
            expected_results.push_back(merge_span(pending_spans.pop_front()));
        end
        if (!span.valid || span.ready) begin
            if (pending_spans.size() > 0 &&
                $urandom_range(99) >= send_idle_pct && rst_n) begin
                span.valid       <= 1'b1;
                span.column_x    <= pending_spans[0].x;
                span.column_z    <= pending_spans[0].z;
                span.span_bottom <= pending_spans[0].bot;
                span.span_top    <= pending_spans[0].top;
                span.area_id     <= pending_spans[0].area;
            end else begin
                span.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request) begin
            hold_cycles <= hold_cycles + 1;
        end else begin
            hold_cycles <= 0;
        end
    end

    // Monitor and receiver stall.
    always @(posedge clk)
    begin
        merge_result_t got;
        merge_result_t want;
        if (result.valid && result.ready) begin
            got.status = result.status;
            got.bot = result.merged_bottom;
            got.top = result.merged_top;
            got.area = result.merged_area;
            got.count = result.column_count;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result transfer: %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result mismatch: expected %p, actual %p", want, got);
                end
            end
        end
        result.ready <= rst_n && !(hold_request && hold_cycles < 300) &&
                        ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic add_span(int x, int z, int b, int t, int a);
        span_item_t it;
        it.x = X_BITS'(x);
        it.z = Z_BITS'(z);
        it.bot = HEIGHT_BITS'(b);
        it.top = HEIGHT_BITS'(t);
        it.area = AREA_BITS'(a);
        pending_spans.push_back(it);
    endtask

    task automatic drain();
        while (pending_spans.size() != 0 || expected_results.size() != 0 || span.valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_BITS'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_GRID_WIDTH) cur_grid_width = value & 7'h7f;
        else cur_threshold = value & 13'h1fff;
    endtask

    task automatic random_phase(int n);
        int x;
        int z;
        int b;
        for (int i = 0; i < n; i++) begin
            x = $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(3);
            z = $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(2);
            if ($urandom_range(9) == 0) begin
                add_span(x, z, $urandom_range(8191), $urandom_range(8191), $urandom_range(255));
            end else begin
                b = $urandom_range(3) == 0 ? 8191 - $urandom_range(60) : $urandom_range(120);
                add_span(x, z, b, (b + $urandom_range(6)) & 13'h1fff, $urandom_range(255));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_GRID_WIDTH;
        cfg_data = '0;
        span.valid = 1'b0;
        span.column_x = '0;
        span.column_z = '0;
        span.span_bottom = '0;
        span.span_top = '0;
        span.area_id = '0;
        result.ready = 1'b0;
        mismatch_count = 0;
        hold_request = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 77;
        cur_grid_width = GRID_WIDTH_RESET;
        cur_threshold = THRESHOLD_RESET;
        foreach (column_fill[i]) column_fill[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        add_span(0, 0, 10, 20, 5);
        add_span(0, 0, 20, 30, 9);
        add_span(0, 0, 31, 40, 200);
        add_span(0, 0, 5, 5, 255);
        add_span(0, 0, 50, 45, 1);
        add_span(0, 0, 0, 8191, 0);
        add_span(63, 63, 8191, 8191, 255);
        add_span(63, 63, 0, 0, 0);
        for (int i = 0; i < 9; i++) add_span(1, 0, i * 4, i * 4 + 1, i);
        add_span(1, 0, 100, 101, 7);
        add_span(1, 0, 0, 40, 3);
        add_span(42, 21, 7, 9, 128);
        add_span(63, 0, 1, 2, 3);
        drain();

        write_reg(CFG_GRID_WIDTH, 0);
        write_reg(CFG_MERGE_THRESHOLD, 0);
        add_span(0, 0, 1, 2, 3);
        random_phase(40);
        drain();

        write_reg(CFG_GRID_WIDTH, 127);
        write_reg(CFG_MERGE_THRESHOLD, 8191);
        add_span(0, 32, 1, 2, 3);
        add_span(31, 31, 1, 2, 3);
        random_phase(360);
        drain();

        send_idle_pct = 77;
        recv_idle_pct = 25;
        write_reg(CFG_GRID_WIDTH, 1);
        write_reg(CFG_MERGE_THRESHOLD, 3);
        random_phase(300);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_GRID_WIDTH, 5);
        write_reg(CFG_MERGE_THRESHOLD, 2);
        hold_request = 1'b1;
        random_phase(300);
        while (hold_cycles < 300) @(posedge clk);
        hold_request = 1'b0;
        drain();

        write_reg(CFG_GRID_WIDTH, 64);
        write_reg(CFG_MERGE_THRESHOLD, 1);
        random_phase(280);
        drain();

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
